// ===== hw/rtl/jspe_pkg.sv =====
package jspe_pkg;

    localparam int MAX_JOBS = 64;
    localparam int IDX_W    = $clog2(MAX_JOBS);
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);
    localparam int TIME_W   = 20;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [2:0] POL_FCFS = 3'd0;
    localparam logic [2:0] POL_SJF  = 3'd1;
    localparam logic [2:0] POL_LJF  = 3'd2;
    localparam logic [2:0] POL_SRTF = 3'd3;
    localparam logic [2:0] POL_LRTF = 3'd4;

    typedef struct packed {
        logic [7:0]        id;
        logic [11:0]       arr;
        logic [11:0]       burst;
        logic [11:0]       rem;
        logic [TIME_W-1:0] first;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

endpackage

// ===== hw/rtl/jspe_in_if.sv =====
interface jspe_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [7:0]  job_id;
    logic [11:0] arrival;
    logic [11:0] burst;
    modport source (output valid, cmd, job_id, arrival, burst, input ready);
    modport sink   (input valid, cmd, job_id, arrival, burst, output ready);
endinterface

// ===== hw/rtl/jspe_out_if.sv =====
interface jspe_out_if;
    logic        valid;
    logic        ready;
    logic        idle;
    logic [7:0]  running_id;
    logic        finished;
    logic [19:0] comp_tick;
    logic [19:0] turnaround;
    logic [19:0] waiting;
    logic [19:0] response;
    logic        all_done;
    modport source (output valid, idle, running_id, finished, comp_tick, turnaround,
                    waiting, response, all_done, input ready);
    modport sink   (input valid, idle, running_id, finished, comp_tick, turnaround,
                    waiting, response, all_done, output ready);
endinterface

// ===== hw/rtl/jspe_ram.sv =====
module jspe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hw/rtl/jspe_cmp.sv =====
// Policy compare: true when the candidate is strictly preferred over the best so far.
module jspe_cmp
    import jspe_pkg::*;
(
    input  logic [2:0] i_policy,
    input  t_slot      i_cand,
    input  t_slot      i_best,
    output logic       o_beats
);
    logic [11:0] key_c;
    logic [11:0] key_b;
    logic        less_wins;
    logic [12:0] tie_c;
    logic [12:0] tie_b;

    always_comb begin
        less_wins = 1'b1;
        case (i_policy)
            POL_SJF: begin
                key_c = i_cand.burst; key_b = i_best.burst;
            end
            POL_LJF: begin
                key_c = i_cand.burst; key_b = i_best.burst; less_wins = 1'b0;
            end
            POL_SRTF: begin
                key_c = i_cand.rem; key_b = i_best.rem;
            end
            POL_LRTF: begin
                key_c = i_cand.rem; key_b = i_best.rem; less_wins = 1'b0;
            end
            default: begin
                key_c = i_cand.arr; key_b = i_best.arr;
            end
        endcase
        tie_c = {1'b0, i_cand.arr} + {1'b0, i_cand.burst};
        tie_b = {1'b0, i_best.arr} + {1'b0, i_best.burst};
        if (key_c != key_b) begin
            o_beats = less_wins ? (key_c < key_b) : (key_c > key_b);
        end else begin
            o_beats = tie_c > tie_b;
        end
    end
endmodule

// ===== hw/rtl/job_scheduling_policy_engine_core.sv =====
// Load and clear transactions are accepted back to back.
// A tick scans the table (the scan is skipped when a held job continues, and reads nothing for an
// empty table), then updates the picked slot; the next transaction is taken once the result is registered.
// The slot table is read one slot per cycle through a single RAM read port and one shared
// compare unit. A result not yet taken stalls only the update step of the next tick.
// Synchronous active-low reset: empty table, time zero, policy 0, no result pending.
module job_scheduling_policy_engine_core
    import jspe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_wdata,
    jspe_in_if.sink           i_job,
    jspe_out_if.source        o_res
);
    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0]        r_st;
    logic [2:0]        r_policy;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_ndone;
    logic [TIME_W-1:0] r_now;
    logic [IDX_W-1:0]  r_held;
    logic              r_held_vld;
    logic [MAX_JOBS-1:0] r_started;
    logic [MAX_JOBS-1:0] r_done;

    // scan pipeline
    logic [CNT_W-1:0]  r_idx;
    logic              r_rd_vld;
    logic              r_rd_force;
    logic [IDX_W-1:0]  r_rd_idx;
    logic              r_found;
    logic [IDX_W-1:0]  r_pick;
    t_slot             r_best;

    // result register
    logic              r_ov;
    logic              r_o_idle;
    logic [7:0]        r_o_id;
    logic              r_o_fin;
    logic [TIME_W-1:0] r_o_comp;
    logic [TIME_W-1:0] r_o_ta;
    logic [TIME_W-1:0] r_o_wait;
    logic [TIME_W-1:0] r_o_resp;
    logic              r_o_all;

    logic [2:0]        eff_pol;
    logic              nonpre;
    logic              acc;
    logic              held_ok;
    logic              upd_go;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    t_slot             ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    t_slot             ram_rdata;
    t_slot             load_slot;
    t_slot             upd_slot;
    logic              beats;
    logic              elig;

    logic [TIME_W-1:0] now_inc;
    logic [TIME_W-1:0] first_eff;
    logic [TIME_W-1:0] ta;
    logic              fin;
    logic              fin_ok;
    logic [CNT_W-1:0]  ndone_n;

    assign eff_pol = (r_policy > POL_LRTF) ? POL_FCFS : r_policy;
    assign nonpre  = eff_pol <= POL_LJF;
    assign i_job.ready = (r_st == ST_IDLE);
    assign acc     = i_job.valid && i_job.ready;
    assign held_ok = nonpre && r_held_vld && ({1'b0, r_held} < r_count) && !r_done[r_held];
    // update step waits until the result register is free
    assign upd_go  = !r_ov || o_res.ready;

    // new table entry; zero burst is stored as one
    always_comb begin
        load_slot       = '0;
        load_slot.id    = i_job.job_id;
        load_slot.arr   = i_job.arrival;
        load_slot.burst = (i_job.burst == '0) ? 12'd1 : i_job.burst;
        load_slot.rem   = load_slot.burst;
    end

    // update of the picked slot
    always_comb begin
        upd_slot  = r_best;
        first_eff = r_started[r_pick] ? r_best.first : r_now;
        upd_slot.first = first_eff;
        if (r_best.rem != '0) begin
            upd_slot.rem = r_best.rem - 12'd1;
        end
        fin     = upd_slot.rem == '0;
        fin_ok  = r_found && fin;
        now_inc = r_now + 1'b1;
        ta      = now_inc - {8'd0, r_best.arr};
        ndone_n = r_ndone + (fin_ok ? 1'b1 : 1'b0);
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pick;
        ram_wdata = upd_slot;
        if (r_st == ST_UPD) begin
            ram_we = r_found && upd_go;
        end else if (acc && i_job.cmd == CMD_LOAD && r_count < MAX_JOBS[CNT_W-1:0]) begin
            ram_we    = 1'b1;
            ram_waddr = r_count[IDX_W-1:0];
            ram_wdata = load_slot;
        end
        if (r_st == ST_IDLE) begin
            ram_raddr = r_held;
        end else begin
            ram_raddr = r_idx[IDX_W-1:0];
        end
    end

    jspe_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_JOBS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    jspe_cmp u_cmp (
        .i_policy (eff_pol),
        .i_cand   (ram_rdata),
        .i_best   (r_best),
        .o_beats  (beats)
    );

    // arrived and unfinished, or the held job
    assign elig = r_rd_force ||
                  (!r_done[r_rd_idx] && ({8'd0, ram_rdata.arr} <= r_now));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= ST_IDLE;
            r_policy   <= POL_FCFS;
            r_count    <= '0;
            r_ndone    <= '0;
            r_now      <= '0;
            r_held     <= '0;
            r_held_vld <= 1'b0;
            r_started  <= '0;
            r_done     <= '0;
            r_idx      <= '0;
            r_rd_vld   <= 1'b0;
            r_rd_force <= 1'b0;
            r_found    <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_policy <= i_cfg_wdata;
            end
            if ((r_st == ST_UPD) && upd_go) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
            case (r_st)
                ST_IDLE: begin
                    if (acc) begin
                        case (i_job.cmd)
                            CMD_LOAD: begin
                                if (r_count < MAX_JOBS[CNT_W-1:0]) begin
                                    r_started[r_count[IDX_W-1:0]] <= 1'b0;
                                    r_done[r_count[IDX_W-1:0]]    <= 1'b0;
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            CMD_CLEAR: begin
                                r_count    <= '0;
                                r_ndone    <= '0;
                                r_now      <= '0;
                                r_held     <= '0;
                                r_held_vld <= 1'b0;
                                r_started  <= '0;
                                r_done     <= '0;
                            end
                            CMD_TICK: begin
                                r_found <= 1'b0;
                                r_st    <= ST_SCAN;
                                if (held_ok) begin
                                    // held slot read now, scan skipped
                                    r_rd_vld   <= 1'b1;
                                    r_rd_force <= 1'b1;
                                    r_rd_idx   <= r_held;
                                    r_idx      <= r_count;
                                end else begin
                                    r_rd_vld   <= 1'b0;
                                    r_rd_force <= 1'b0;
                                    r_idx      <= '0;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (r_rd_vld && elig && (!r_found || r_rd_force || beats)) begin
                        r_found <= 1'b1;
                        r_pick  <= r_rd_idx;
                        r_best  <= ram_rdata;
                    end
                    if (r_idx < r_count) begin
                        r_rd_vld <= 1'b1;
                        r_rd_idx <= r_idx[IDX_W-1:0];
                        r_idx    <= r_idx + 1'b1;
                    end else begin
                        r_rd_vld <= 1'b0;
                        if (!r_rd_vld) begin
                            r_st <= ST_UPD;
                        end
                    end
                end
                ST_UPD: begin
                    if (upd_go) begin
                        r_st       <= ST_IDLE;
                        r_rd_force <= 1'b0;
                        r_now      <= now_inc;
                        r_o_idle   <= !r_found;
                        r_o_id     <= r_found ? r_best.id : 8'd0;
                        r_o_fin    <= fin_ok;
                        r_o_comp   <= fin_ok ? now_inc : '0;
                        r_o_ta     <= fin_ok ? ta : '0;
                        r_o_wait   <= fin_ok ? (ta - {8'd0, r_best.burst}) : '0;
                        r_o_resp   <= fin_ok ? (first_eff - {8'd0, r_best.arr}) : '0;
                        r_o_all    <= ndone_n == r_count;
                        r_ndone    <= ndone_n;
                        if (r_found) begin
                            r_started[r_pick] <= 1'b1;
                            if (nonpre) begin
                                r_held <= r_pick;
                            end
                            if (fin) begin
                                r_done[r_pick] <= 1'b1;
                                r_held_vld     <= 1'b0;
                            end else if (nonpre) begin
                                r_held_vld     <= 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    r_st <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid      = r_ov;
    assign o_res.idle       = r_o_idle;
    assign o_res.running_id = r_o_id;
    assign o_res.finished   = r_o_fin;
    assign o_res.comp_tick  = r_o_comp;
    assign o_res.turnaround = r_o_ta;
    assign o_res.waiting    = r_o_wait;
    assign o_res.response   = r_o_resp;
    assign o_res.all_done   = r_o_all;
endmodule
